@@ rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Request and response word layouts, operation codes, default sizes.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DEFAULT_DEPTH      = 16;
  localparam int DEFAULT_VALUE_BITS = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] data;
    logic [4:0]         count;
  } out_word_t;

endpackage

@@ rtl/indexed_list_store.sv @@
// Sequencing: clear, rejected and unknown requests respond without touching storage; read
// fetches one entry; insert and delete shift the entries between position and the top;
// find scans from the top down to the first match, or to the bottom on a miss.
// Throughput: one request in flight; the next is accepted only after the last result is
// passed to the output register, held further by any output stall.
// Reset: rst_n synchronous, active low; empties the list, storage is not cleared.
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list with insert, delete, read, find and clear
// Top level: sequencer, storage and response output register.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int DEPTH      = ils_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS = ils_pkg::DEFAULT_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ils_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ils_pkg::out_word_t out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  ils_pkg::out_word_t    res_word;
  logic [CW-1:0]         cnt;

  logic                  out_valid_r, out_valid_nxt;
  ils_pkg::out_word_t    out_word_r, out_word_nxt;

  ils_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cnt_o     (cnt)
  );

  ils_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_word_nxt = res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a request is in flight");

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("response word raised without a finished request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CW'(DEPTH))
    else $error("entry count exceeds list depth");
`endif

endmodule

@@ rtl/ils_ram.sv @@
// ----------------------------------------------------------------------------
// ils_ram: list storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int DEPTH = ils_pkg::DEFAULT_DEPTH,
  parameter int WIDTH = ils_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl: list sequencer
// Walks the storage one entry per step with a single index counter and one
// equality compare: shifts for insert and delete, backward scan for find, one fetch for read.
// ----------------------------------------------------------------------------
module ils_ctrl #(
  parameter int DEPTH      = ils_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS = ils_pkg::DEFAULT_VALUE_BITS,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ils_pkg::in_word_t     in_word,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [VALUE_BITS-1:0] mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [VALUE_BITS-1:0] mem_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ils_pkg::out_word_t    res_word,
  output logic [CW-1:0]         cnt_o
);

  localparam int XW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH,
    S_CMP,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [XW-1:0]         pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  status_r, status_nxt;
  logic signed [31:0]    data_r, data_nxt;

  logic [CW-1:0]         idx_dec;
  logic [CW-1:0]         idx_inc;
  logic [XW-1:0]         in_pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         idx_x;
  logic [63:0]           in_wide;
  logic signed [63:0]    rd_wide;

  assign idx_dec  = idx_r - 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign in_pos_x = XW'(in_word.position);
  assign cnt_x    = XW'(cnt_r);
  assign idx_x    = XW'(idx_r);
  assign in_wide  = 64'(in_word.item_value);
  assign rd_wide  = 64'(signed'(mem_rdata));

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign cnt_o     = cnt_r;

  always_comb begin
    res_word.status = status_r;
    res_word.data   = data_r;
    res_word.count  = 5'(cnt_r);
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_dec[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_word.op;
          pos_nxt    = in_pos_x;
          val_nxt    = in_wide[VALUE_BITS-1:0];
          status_nxt = 1'b1;
          data_nxt   = '0;
          state_nxt  = S_DONE;
          case (in_word.op)
            ils_pkg::OP_INSERT: begin
              if (in_pos_x <= cnt_x && cnt_r < CW'(DEPTH)) begin
                idx_nxt   = cnt_r;
                state_nxt = S_SHIFT_RD;
              end
            end
            ils_pkg::OP_DELETE: begin
              if (in_pos_x < cnt_x) begin
                idx_nxt   = CW'(in_pos_x);
                state_nxt = S_SHIFT_RD;
              end
            end
            ils_pkg::OP_READ: begin
              if (in_pos_x < cnt_x) begin
                idx_nxt   = CW'(in_pos_x) + 1'b1;
                state_nxt = S_FETCH;
              end
            end
            ils_pkg::OP_FIND: begin
              idx_nxt   = cnt_r;
              state_nxt = S_FETCH;
            end
            ils_pkg::OP_CLEAR: begin
              cnt_nxt    = '0;
              status_nxt = 1'b0;
            end
            default: begin
              status_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (op_r == ils_pkg::OP_INSERT) begin
          if (idx_x > pos_r) begin
            mem_raddr = idx_dec[AW-1:0];
            state_nxt = S_SHIFT_WR;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = pos_r[AW-1:0];
            mem_wdata  = val_r;
            cnt_nxt    = cnt_r + 1'b1;
            status_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end else begin
          if (idx_inc < cnt_r) begin
            mem_raddr = idx_inc[AW-1:0];
            state_nxt = S_SHIFT_WR;
          end else begin
            cnt_nxt    = cnt_r - 1'b1;
            status_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = (op_r == ils_pkg::OP_INSERT) ? idx_dec : idx_inc;
        state_nxt = S_SHIFT_RD;
      end
      S_FETCH: begin
        if (idx_r != '0) begin
          mem_raddr = idx_dec[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (op_r == ils_pkg::OP_READ) begin
          data_nxt   = rd_wide[31:0];
          status_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else if (mem_rdata == val_r) begin
          data_nxt   = 32'(idx_dec);
          status_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

endmodule
